// ----- hw/rtl/dvs_pkg.sv -----
// dvs_pkg: shared constants and helpers for the double value sorter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dvs_pkg;
   localparam int DefMaxItems = 64;
   localparam int ValueWidth = 64;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_DRAIN
   } state_type;

   function automatic logic [ValueWidth-1:0] order_key(input logic [ValueWidth-1:0] bits);
      order_key = bits[ValueWidth-1] ? ~bits : (bits | {1'b1, {(ValueWidth-1){1'b0}}});
   endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/dvs_cell.sv -----
// dvs_cell: one insertion cell; keeps the smaller key, passes the larger on.
// Depends on dvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dvs_cell
   import dvs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  ins_en,
   input  wire logic                  shift_en,
   input  wire logic                  in_valid,
   input  wire logic [ValueWidth-1:0] in_value,
   input  wire logic                  nxt_valid,
   input  wire logic [ValueWidth-1:0] nxt_value,
   output logic                       out_valid,
   output logic [ValueWidth-1:0]      out_value,
   output logic                       hold_valid,
   output logic [ValueWidth-1:0]      hold_value
);
   logic                  hold_valid_ff, hold_valid_in;
   logic [ValueWidth-1:0] hold_value_ff, hold_value_in;
   logic                  out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0] out_value_ff, out_value_in;
   logic                  keep_new;

   assign keep_new = in_valid &&
      (!hold_valid_ff || (order_key(in_value) < order_key(hold_value_ff)));

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_value_in = hold_value_ff;
      out_valid_in = 1'b0;
      out_value_in = out_value_ff;
      if (shift_en) begin
         hold_valid_in = nxt_valid;
         hold_value_in = nxt_value;
      end else if (ins_en && in_valid) begin
         hold_valid_in = 1'b1;
         if (keep_new) begin
            hold_value_in = in_value;
            out_valid_in = hold_valid_ff;
            out_value_in = hold_value_ff;
         end else begin
            out_valid_in = 1'b1;
            out_value_in = in_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff <= out_valid_in;
      end
      hold_value_ff <= hold_value_in;
      out_value_ff <= out_value_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign hold_valid = hold_valid_ff;
   assign hold_value = hold_value_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/double_value_sorter.sv -----
// double_value_sorter: insertion chain of dvs_cell, ascending drain.
// Depends on dvs_pkg, dvs_cell.
//  channel | dir | ports
//  req     | in  | req_valid req_ready req_value req_last
//  rsp     | out | rsp_valid rsp_ready rsp_sorted_value rsp_final_res rsp_overflow
// One value enters per cycle while filling; cell k settles in the cycle after
// cell k-1. After last, the chain flushes, then one result per cycle while
// rsp_ready is high, read from cell 0 as the chain shifts down. No input is
// taken while draining. Reset empties all cells; stalls on rsp hold the chain.
`timescale 1ns / 1ps
`default_nettype none
module double_value_sorter
   import dvs_pkg::*;
#(
   parameter int MAX_ITEMS = DefMaxItems
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [ValueWidth-1:0] req_value,
   input  wire logic                  req_last,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [ValueWidth-1:0]      rsp_sorted_value,
   output logic                       rsp_final_res,
   output logic                       rsp_overflow
);
   localparam int CntW = $clog2(MAX_ITEMS + 1);

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in, flush_ff, flush_in;
   logic drop_ff, drop_in;
   logic acc, shift_en, ins_en, store;
   logic                  cv [MAX_ITEMS+1];
   logic [ValueWidth-1:0] cd [MAX_ITEMS+1];
   logic                  hv [MAX_ITEMS+1];
   logic [ValueWidth-1:0] hd [MAX_ITEMS+1];

   assign req_ready = (state_ff == ST_FILL);
   assign acc = req_valid && req_ready;
   assign store = acc && (count_ff != CntW'(MAX_ITEMS));
   assign rsp_valid = (state_ff == ST_DRAIN) && (flush_ff == CntW'(MAX_ITEMS));
   assign shift_en = rsp_valid && rsp_ready;
   assign ins_en = !rsp_valid;
   assign cv[0] = store;
   assign cd[0] = req_value;
   assign hv[MAX_ITEMS] = 1'b0;
   assign hd[MAX_ITEMS] = '0;

   for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
      dvs_cell u_cell (
         .clock(clock), .reset(reset), .ins_en(ins_en), .shift_en(shift_en),
         .in_valid(cv[k]), .in_value(cd[k]),
         .nxt_valid(hv[k+1]), .nxt_value(hd[k+1]),
         .out_valid(cv[k+1]), .out_value(cd[k+1]),
         .hold_valid(hv[k]), .hold_value(hd[k])
      );
   end

   assign rsp_sorted_value = hd[0];
   assign rsp_final_res = (count_ff == CntW'(1));
   assign rsp_overflow = drop_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL:  if (acc && req_last) state_in = ST_DRAIN;
         ST_DRAIN: if (shift_en && rsp_final_res) state_in = ST_FILL;
         default:  state_in = ST_FILL;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      drop_in = drop_ff;
      flush_in = flush_ff;
      unique case (state_ff)
         ST_FILL: begin
            flush_in = '0;
            if (store) count_in = count_ff + CntW'(1);
            else if (acc) drop_in = 1'b1;
         end
         ST_DRAIN: begin
            if (flush_ff != CntW'(MAX_ITEMS)) flush_in = flush_ff + CntW'(1);
            if (shift_en) begin
               count_in = count_ff - CntW'(1);
               if (rsp_final_res) drop_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         count_ff <= '0;
         drop_ff <= 1'b0;
         flush_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff <= drop_in;
         flush_ff <= flush_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_ITEMS)) else $error("count over capacity");
   a_no_req_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input open while draining");
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0) else $error("result with empty set");
`endif
endmodule
`default_nettype wire
